@@ sv/rnp_pkg.sv @@
package rnp_pkg;

  localparam int DEF_MAX_ELEMENTS = 16;
  localparam int DEF_NUM_WIDTH    = 32;
  localparam int LEN_W            = 5;
  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_READ = 2'd1,
    OP_ADV  = 2'd2,
    OP_SKIP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_END = 2'd1,
    ST_BAD = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    WSEL_IN  = 2'd0,
    WSEL_A   = 2'd1,
    WSEL_B   = 2'd2,
    WSEL_TMP = 2'd3
  } wsel_e;

  typedef struct packed {
    op_e                opcode;
    logic [3:0]         position;
    logic signed [31:0] numerator;
    logic [31:0]        denominator;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic [3:0]         pivot_index;
    logic signed [31:0] read_numerator;
    logic [31:0]        read_denominator;
  } out_word_t;

  typedef struct packed {
    logic  cap;
    logic  rd;
    logic  a_tmp;
    logic  mul1;
    logic  mul2;
    logic  cmp;
    logic  we;
    wsel_e wsel;
    logic  tmp_ld;
    logic  out_ld;
    logic  out_rd;
  } dp_cmd_t;

endpackage

@@ sv/rnp_datapath.sv @@
module rnp_datapath #(
  parameter int MAX_ELEMENTS = 16,
  parameter int NUM_WIDTH    = 32,
  localparam int IW          = $clog2(MAX_ELEMENTS)
) (
  input  logic               clk_i,
  input  rnp_pkg::dp_cmd_t   cmd_i,
  input  logic [IW-1:0]      addr_a_i,
  input  logic [IW-1:0]      addr_b_i,
  input  logic [IW-1:0]      waddr_i,
  input  logic signed [31:0] in_num_i,
  input  logic [31:0]        in_den_i,
  output logic               lt_o,
  output logic signed [31:0] rd_num_o,
  output logic [31:0]        rd_den_o
);
  import rnp_pkg::*;

  localparam int NW = NUM_WIDTH;
  localparam int PW = 2 * NW + 2;

  logic [NW-1:0] num_mem [MAX_ELEMENTS];
  logic [NW-1:0] den_mem [MAX_ELEMENTS];

  logic [NW-1:0] in_num_q, in_den_q;
  logic [NW-1:0] a_num_q, a_den_q, b_num_q, b_den_q;
  logic [NW-1:0] t_num_q, t_den_q;
  logic signed [PW-1:0] p1_q, p2_q, prod;
  logic [NW-1:0] mul_a, mul_b, w_num, w_den;
  logic lt_q;
  logic signed [31:0] rd_num_q;
  logic [31:0] rd_den_q;

  assign mul_a = cmd_i.mul2 ? b_num_q : a_num_q;
  assign mul_b = cmd_i.mul2 ? a_den_q : b_den_q;
  assign prod  = $signed({mul_a[NW-1], mul_a}) * $signed({1'b0, mul_b});

  always_comb begin
    unique case (cmd_i.wsel)
      WSEL_IN:  begin w_num = in_num_q; w_den = in_den_q; end
      WSEL_A:   begin w_num = a_num_q;  w_den = a_den_q;  end
      WSEL_B:   begin w_num = b_num_q;  w_den = b_den_q;  end
      default:  begin w_num = t_num_q;  w_den = t_den_q;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      in_num_q <= NW'(in_num_i);
      in_den_q <= NW'(in_den_i);
    end
    if (cmd_i.we) begin
      num_mem[waddr_i] <= w_num;
      den_mem[waddr_i] <= w_den;
    end
    if (cmd_i.rd) begin
      if (cmd_i.a_tmp) begin
        a_num_q <= t_num_q;
        a_den_q <= t_den_q;
      end else begin
        a_num_q <= num_mem[addr_a_i];
        a_den_q <= den_mem[addr_a_i];
      end
      b_num_q <= num_mem[addr_b_i];
      b_den_q <= den_mem[addr_b_i];
    end
    if (cmd_i.tmp_ld) begin
      t_num_q <= a_num_q;
      t_den_q <= a_den_q;
    end
    if (cmd_i.mul1) p1_q <= prod;
    if (cmd_i.mul2) p2_q <= prod;
    if (cmd_i.cmp)  lt_q <= p1_q < p2_q;
    if (cmd_i.out_ld) begin
      rd_num_q <= cmd_i.out_rd ? 32'(a_num_q) : '0;
      rd_den_q <= cmd_i.out_rd ? 32'(a_den_q) : '0;
    end
  end

  assign lt_o     = lt_q;
  assign rd_num_o = rd_num_q;
  assign rd_den_o = rd_den_q;

endmodule

@@ sv/rnp_ctrl.sv @@
module rnp_ctrl #(
  parameter int MAX_ELEMENTS = 16,
  localparam int IW          = $clog2(MAX_ELEMENTS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  rnp_pkg::op_e              opcode_i,
  input  logic [3:0]                position_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output rnp_pkg::status_e          status_o,
  output logic [3:0]                pivot_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [rnp_pkg::LEN_W-1:0] cfg_data_i,
  input  logic                      lt_i,
  output rnp_pkg::dp_cmd_t          cmd_o,
  output logic [IW-1:0]             addr_a_o,
  output logic [IW-1:0]             addr_b_o,
  output logic [IW-1:0]             waddr_o
);
  import rnp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_FINISH,
    S_CMP_RD, S_CMP_M1, S_CMP_M2, S_CMP_C,
    S_SW_RD, S_SW_W1, S_SW_W2,
    S_REV_CHK, S_REV_NEXT,
    S_ADV_START, S_ADV_CHK, S_ADV_LCHK, S_ADV_LRES, S_ADV_SWAP, S_ADV_REV, S_ADV_DONE,
    S_SK_CMP, S_SK_CHK, S_SK_RD, S_SK_WR, S_SK_TST, S_SK_MORE, S_SK_PUT
  } state_e;

  state_e state_q, cret_q, sret_q, rret_q;
  op_e op_q;
  logic [3:0] pos_q;
  logic [LEN_W-1:0] len_q;
  logic [IW-1:0] p_q, l_q, lo_q, hi_q, ca_q, cb_q, sa_q, sb_q;
  logic ctmp_q, rd_q, out_valid_q;
  status_e st_q, out_st_q;
  logic [3:0] pv_q, out_pv_q;

  logic pos_oor, len_big, len_small, out_free;
  logic [IW-1:0] pos_ix, last_ix;

  assign pos_oor   = 32'(pos_q) >= 32'(MAX_ELEMENTS);
  assign len_big   = 32'(len_q) > 32'(MAX_ELEMENTS);
  assign len_small = len_q < LEN_W'(2);
  assign pos_ix    = IW'(pos_q);
  assign last_ix   = IW'(len_q - LEN_W'(1));
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o    = '0;
    cmd_o.wsel = WSEL_IN;
    addr_a_o = '0;
    addr_b_o = '0;
    waddr_o  = '0;
    unique case (state_q)
      S_IDLE: cmd_o.cap = in_valid_i;
      S_DECODE: begin
        if (op_q == OP_LOAD && !pos_oor) begin
          cmd_o.we = 1'b1;
          waddr_o  = pos_ix;
        end else if (op_q == OP_READ && !pos_oor) begin
          cmd_o.rd = 1'b1;
          addr_a_o = pos_ix;
        end
      end
      S_CMP_RD: begin
        cmd_o.rd    = 1'b1;
        cmd_o.a_tmp = ctmp_q;
        addr_a_o    = ca_q;
        addr_b_o    = cb_q;
      end
      S_CMP_M1: cmd_o.mul1 = 1'b1;
      S_CMP_M2: cmd_o.mul2 = 1'b1;
      S_CMP_C:  cmd_o.cmp  = 1'b1;
      S_SW_RD: begin
        cmd_o.rd = 1'b1;
        addr_a_o = sa_q;
        addr_b_o = sb_q;
      end
      S_SW_W1: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = WSEL_B;
        waddr_o    = sa_q;
      end
      S_SW_W2: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = WSEL_A;
        waddr_o    = sb_q;
      end
      S_SK_CHK: cmd_o.tmp_ld = lt_i;
      S_SK_RD: begin
        cmd_o.rd = 1'b1;
        addr_a_o = l_q;
        addr_b_o = l_q + IW'(1);
      end
      S_SK_WR: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = WSEL_B;
        waddr_o    = l_q;
      end
      S_SK_PUT: begin
        cmd_o.we   = 1'b1;
        cmd_o.wsel = WSEL_TMP;
        waddr_o    = l_q;
      end
      S_FINISH: begin
        cmd_o.out_ld = out_free;
        cmd_o.out_rd = rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= LEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) len_q <= cfg_data_i;
      if (state_q == S_FINISH && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= opcode_i;
            pos_q   <= position_i;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          pv_q <= '0;
          rd_q <= (op_q == OP_READ) && !pos_oor;
          unique case (op_q)
            OP_LOAD, OP_READ: begin
              st_q    <= pos_oor ? ST_BAD : ST_OK;
              state_q <= S_FINISH;
            end
            OP_ADV: begin
              if (len_big) begin
                st_q    <= ST_BAD;
                state_q <= S_FINISH;
              end else if (len_small) begin
                st_q    <= ST_END;
                state_q <= S_FINISH;
              end else begin
                st_q    <= ST_OK;
                p_q     <= IW'(len_q - LEN_W'(2));
                state_q <= S_ADV_START;
              end
            end
            default: begin
              if (len_small || len_big || LEN_W'(pos_q) >= len_q - LEN_W'(1)) begin
                st_q    <= ST_BAD;
                state_q <= S_FINISH;
              end else begin
                st_q    <= ST_OK;
                lo_q    <= pos_ix + IW'(1);
                hi_q    <= last_ix;
                rret_q  <= S_SK_CMP;
                state_q <= S_REV_CHK;
              end
            end
          endcase
        end
        S_CMP_RD: state_q <= S_CMP_M1;
        S_CMP_M1: state_q <= S_CMP_M2;
        S_CMP_M2: state_q <= S_CMP_C;
        S_CMP_C:  state_q <= cret_q;
        S_SW_RD:  state_q <= S_SW_W1;
        S_SW_W1:  state_q <= S_SW_W2;
        S_SW_W2:  state_q <= sret_q;
        S_REV_CHK: begin
          if (lo_q < hi_q) begin
            sa_q    <= lo_q;
            sb_q    <= hi_q;
            sret_q  <= S_REV_NEXT;
            state_q <= S_SW_RD;
          end else begin
            state_q <= rret_q;
          end
        end
        S_REV_NEXT: begin
          lo_q    <= lo_q + IW'(1);
          hi_q    <= hi_q - IW'(1);
          state_q <= S_REV_CHK;
        end
        S_ADV_START: begin
          ca_q    <= p_q;
          cb_q    <= p_q + IW'(1);
          ctmp_q  <= 1'b0;
          cret_q  <= S_ADV_CHK;
          state_q <= S_CMP_RD;
        end
        S_ADV_CHK: begin
          if (lt_i) begin
            l_q     <= last_ix;
            state_q <= S_ADV_LCHK;
          end else if (p_q == '0) begin
            st_q    <= ST_END;
            state_q <= S_FINISH;
          end else begin
            p_q     <= p_q - IW'(1);
            state_q <= S_ADV_START;
          end
        end
        S_ADV_LCHK: begin
          if ({1'b0, l_q} > {1'b0, p_q} + (IW+1)'(1)) begin
            ca_q    <= p_q;
            cb_q    <= l_q;
            ctmp_q  <= 1'b0;
            cret_q  <= S_ADV_LRES;
            state_q <= S_CMP_RD;
          end else begin
            state_q <= S_ADV_SWAP;
          end
        end
        S_ADV_LRES: begin
          if (lt_i) state_q <= S_ADV_SWAP;
          else begin
            l_q     <= l_q - IW'(1);
            state_q <= S_ADV_LCHK;
          end
        end
        S_ADV_SWAP: begin
          sa_q    <= p_q;
          sb_q    <= l_q;
          sret_q  <= S_ADV_REV;
          state_q <= S_SW_RD;
        end
        S_ADV_REV: begin
          lo_q    <= p_q + IW'(1);
          hi_q    <= last_ix;
          rret_q  <= S_ADV_DONE;
          state_q <= S_REV_CHK;
        end
        S_ADV_DONE: begin
          pv_q    <= 4'(p_q);
          state_q <= S_FINISH;
        end
        S_SK_CMP: begin
          ca_q    <= pos_ix;
          cb_q    <= pos_ix + IW'(1);
          ctmp_q  <= 1'b0;
          cret_q  <= S_SK_CHK;
          state_q <= S_CMP_RD;
        end
        S_SK_CHK: begin
          if (lt_i) begin
            l_q     <= pos_ix;
            state_q <= S_SK_RD;
          end else begin
            p_q     <= pos_ix;
            state_q <= S_ADV_START;
          end
        end
        S_SK_RD: state_q <= S_SK_WR;
        S_SK_WR: begin
          l_q     <= l_q + IW'(1);
          state_q <= S_SK_TST;
        end
        S_SK_TST: begin
          if (l_q < last_ix) begin
            ca_q    <= l_q;
            cb_q    <= l_q;
            ctmp_q  <= 1'b1;
            cret_q  <= S_SK_MORE;
            state_q <= S_CMP_RD;
          end else begin
            state_q <= S_SK_PUT;
          end
        end
        S_SK_MORE: state_q <= lt_i ? S_SK_RD : S_SK_PUT;
        S_SK_PUT: begin
          p_q     <= pos_ix;
          state_q <= S_ADV_START;
        end
        S_FINISH: begin
          if (out_free) begin
            out_st_q    <= st_q;
            out_pv_q    <= pv_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_st_q;
  assign pivot_o     = out_pv_q;

endmodule

@@ sv/rational_next_permutation_core.sv @@
// Rational next-permutation engine. Holds MAX_ELEMENTS rationals and steps the
// first length_in_use of them to the next lexicographic permutation; one result
// word per input word. Load and read pass through the accept, decode and result
// states. Advance and skip run as a sequence over the element store through one
// shared multiplier: each element compare runs read, two cross products and
// compare, with a set-up state before it and a decision state after it, and each
// swap runs a read and two writes through the single write port; run length
// depends on pivot depth. Input is stalled while a word is being worked on.
module rational_next_permutation_core #(
  parameter int MAX_ELEMENTS = rnp_pkg::DEF_MAX_ELEMENTS,
  parameter int NUM_WIDTH    = rnp_pkg::DEF_NUM_WIDTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  rnp_pkg::in_word_t         in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output rnp_pkg::out_word_t        out_word_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [rnp_pkg::LEN_W-1:0] cfg_data_i
);
  import rnp_pkg::*;

  localparam int IW = $clog2(MAX_ELEMENTS);

  dp_cmd_t cmd;
  logic [IW-1:0] addr_a, addr_b, waddr;
  logic lt;
  status_e status;
  logic [3:0] pivot;
  logic signed [31:0] rd_num;
  logic [31:0] rd_den;

  rnp_ctrl #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (in_word_i.opcode),
    .position_i  (in_word_i.position),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status),
    .pivot_o     (pivot),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .lt_i        (lt),
    .cmd_o       (cmd),
    .addr_a_o    (addr_a),
    .addr_b_o    (addr_b),
    .waddr_o     (waddr)
  );

  rnp_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS), .NUM_WIDTH(NUM_WIDTH)) u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .addr_a_i (addr_a),
    .addr_b_i (addr_b),
    .waddr_i  (waddr),
    .in_num_i (in_word_i.numerator),
    .in_den_i (in_word_i.denominator),
    .lt_o     (lt),
    .rd_num_o (rd_num),
    .rd_den_o (rd_den)
  );

  assign out_word_o.status           = status;
  assign out_word_o.pivot_index      = pivot;
  assign out_word_o.read_numerator   = rd_num;
  assign out_word_o.read_denominator = rd_den;

endmodule

@@ sv/rnp_checker.sv @@
module rnp_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input rnp_pkg::in_word_t         in_word_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input rnp_pkg::out_word_t        out_word_o,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic [rnp_pkg::LEN_W-1:0] cfg_data_i
);
  import rnp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.status == ST_OK || out_word_o.status == ST_END ||
                     out_word_o.status == ST_BAD))
    else $error("undefined status");

  a_pivot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != ST_OK |-> out_word_o.pivot_index == 4'd0)
    else $error("pivot set on failed word");

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status != ST_OK |->
      out_word_o.read_numerator == 32'sd0 && out_word_o.read_denominator == 32'd0)
    else $error("read data set on failed word");

endmodule

bind rational_next_permutation_core rnp_checker u_rnp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_data_i  (cfg_data_i)
);
